@@ src/csq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the chunk semaphore with wait queue.
// Used by csq_cell and by the top level chunk_semaphore_with_wait_queue.

package csq_pkg;

    localparam int ID_W            = 4;
    localparam int AMT_W           = 16;
    localparam int CRED_OUT_W      = 16;
    localparam int STATUS_W        = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;
    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int DEF_CREDIT_BITS = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FIFO_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CREDITS = 1'b1;

    localparam logic REQ_OBTAIN  = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_NO_WAIT  = 3'd2,
        ST_FULL     = 3'd3,
        ST_RELEASED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]  owner;
        logic [AMT_W-1:0] amount;
    } t_waiter;

    typedef struct packed {
        logic load;
        logic shift;
        logic recirc;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ src/csq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One cell of the waiter queue: holds a single waiter entry.
// Depends on csq_pkg for the entry and control types.

module csq_cell
    import csq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_waiter    i_new,
    input  wire t_waiter    i_next,
    input  wire t_waiter    i_head,
    output t_waiter         o_entry
);

    t_waiter r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_entry <= i_new;
        end else if (i_ctrl.shift) begin
            if (i_ctrl.recirc) begin
                r_entry <= i_head;
            end else begin
                r_entry <= i_next;
            end
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

@@ src/chunk_semaphore_with_wait_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Top level of the chunk semaphore with wait queue.
// Depends on csq_pkg and on csq_cell for the chain of queue cells.

// The block holds a pool of credits and a queue of up to QUEUE_DEPTH waiters kept in a chain
// of cells that shift toward the head. An obtain transaction is answered with exactly one
// registered result. A release transaction takes the saturating add, then one step for each
// queued waiter, in which the whole chain shifts by one cell while the head entry is either
// granted or recirculated to the tail, then closes the walk and gives the final result, while
// a stalled output holds the walk. Each grant of a release is one result, the last one marked
// by tlast. Configuration writes load the FIFO mode bit (index 0) or the credit count
// (index 1) at once.

module chunk_semaphore_with_wait_queue
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int CREDIT_BITS = DEF_CREDIT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0: requester_id[3:0], amount[19:4], wait_if_short[20], zero pad.
    input  wire logic [23:0]           s_axis_tdata,
    // Fields from bit 0: req_type[0].
    input  wire logic [0:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Fields from bit 0: grant_id[3:0], credits_left[19:4], zero pad.
    output logic [23:0]                m_axis_tdata,
    // Fields from bit 0: status[2:0].
    output logic [STATUS_W-1:0]        m_axis_tuser,
    output logic                       m_axis_tlast
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CREDIT_BITS > AMT_W) ? CREDIT_BITS : AMT_W;
    localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = '1;

    t_state                  r_state, n_state;
    logic [CREDIT_BITS-1:0]  r_credit, n_credit;
    logic                    r_fifo;
    logic [CNT_W-1:0]        r_total;
    logic [CNT_W-1:0]        r_left;
    logic                    r_stop;
    logic [ID_W-1:0]         r_rel_id;
    logic                    r_pend_valid;
    logic [ID_W-1:0]         r_pend_id;
    logic [CRED_OUT_W-1:0]   r_pend_credit;
    logic                    r_out_valid;
    logic [ID_W-1:0]         r_out_id;
    t_status                 r_out_status;
    logic [CRED_OUT_W-1:0]   r_out_credit;
    logic                    r_out_last;

    logic                    req_type;
    logic [ID_W-1:0]         in_id;
    logic [AMT_W-1:0]        in_amount;
    logic                    in_wait;
    logic                    out_free;
    logic                    in_acc;
    logic                    obtain_acc;
    logic                    release_acc;
    logic                    obt_grant;
    logic                    obt_queue;
    t_status                 obt_status;
    logic                    head_ok;
    logic                    step_en;
    logic                    step_grant;
    logic                    done_en;
    logic [CMP_W:0]          rel_sum;
    logic [CMP_W-1:0]        n_credit_ext;
    logic [CRED_OUT_W-1:0]   n_credit_low;
    t_waiter                 new_entry;
    t_waiter                 cell_q [QUEUE_DEPTH];

    assign req_type  = s_axis_tuser[0];
    assign in_id     = s_axis_tdata[3:0];
    assign in_amount = s_axis_tdata[19:4];
    assign in_wait   = s_axis_tdata[20];

    assign out_free    = !r_out_valid || m_axis_tready;
    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign obtain_acc  = in_acc && (req_type == REQ_OBTAIN);
    assign release_acc = in_acc && (req_type == REQ_RELEASE);

    always_comb begin
        obt_grant  = 1'b0;
        obt_queue  = 1'b0;
        obt_status = ST_GRANTED;
        if (!(r_fifo && (r_total != '0)) && (CMP_W'(r_credit) >= CMP_W'(in_amount))) begin
            obt_grant = 1'b1;
        end else if (!in_wait) begin
            obt_status = ST_NO_WAIT;
        end else if (r_total == CNT_W'(QUEUE_DEPTH)) begin
            obt_status = ST_FULL;
        end else begin
            obt_queue  = 1'b1;
            obt_status = ST_QUEUED;
        end
    end

    assign head_ok = !r_stop && (CMP_W'(r_credit) >= CMP_W'(cell_q[0].amount));
    assign rel_sum = (CMP_W + 1)'(r_credit) + (CMP_W + 1)'(in_amount);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (release_acc) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_left == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        step_en       = 1'b0;
        done_en       = 1'b0;
        case (r_state)
            S_IDLE: s_axis_tready = out_free;
            S_WALK: step_en = (r_left != '0) && (!(head_ok && r_pend_valid) || out_free);
            S_DONE: done_en = out_free;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign step_grant = step_en && head_ok;

    always_comb begin
        n_credit = r_credit;
        if (i_cfg_we && (i_cfg_idx == CFG_INIT_CREDITS)) begin
            n_credit = CREDIT_BITS'(CMP_W'(i_cfg_data));
        end else if (obtain_acc && obt_grant) begin
            n_credit = CREDIT_BITS'(CMP_W'(r_credit) - CMP_W'(in_amount));
        end else if (release_acc) begin
            if (rel_sum > (CMP_W + 1)'(CREDIT_MAX)) begin
                n_credit = CREDIT_MAX;
            end else begin
                n_credit = CREDIT_BITS'(rel_sum);
            end
        end else if (step_grant) begin
            n_credit = CREDIT_BITS'(CMP_W'(r_credit) - CMP_W'(cell_q[0].amount));
        end
    end

    assign n_credit_ext = CMP_W'(n_credit);
    assign n_credit_low = n_credit_ext[CRED_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_credit     <= '0;
            r_fifo       <= 1'b1;
            r_total      <= '0;
            r_left       <= '0;
            r_stop       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_credit <= n_credit;
            if (i_cfg_we && (i_cfg_idx == CFG_FIFO_MODE)) begin
                r_fifo <= i_cfg_data[0];
            end
            if (obtain_acc && obt_queue) begin
                r_total <= r_total + 1'b1;
            end else if (step_grant) begin
                r_total <= r_total - 1'b1;
            end
            if (release_acc) begin
                r_left       <= r_total;
                r_stop       <= 1'b0;
                r_pend_valid <= 1'b0;
            end else if (step_en) begin
                r_left <= r_left - 1'b1;
                if (!head_ok && r_fifo) begin
                    r_stop <= 1'b1;
                end
                if (head_ok) begin
                    r_pend_valid <= 1'b1;
                end
            end
            if (obtain_acc || (step_grant && r_pend_valid) || done_en) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (release_acc) begin
            r_rel_id <= in_id;
        end
        if (step_grant) begin
            r_pend_id     <= cell_q[0].owner;
            r_pend_credit <= n_credit_low;
        end
        if (obtain_acc) begin
            r_out_id     <= in_id;
            r_out_status <= obt_grant ? ST_GRANTED : obt_status;
            r_out_credit <= n_credit_low;
            r_out_last   <= 1'b1;
        end else if (step_grant && r_pend_valid) begin
            r_out_id     <= r_pend_id;
            r_out_status <= ST_GRANTED;
            r_out_credit <= r_pend_credit;
            r_out_last   <= 1'b0;
        end else if (done_en) begin
            r_out_last <= 1'b1;
            if (r_pend_valid) begin
                r_out_id     <= r_pend_id;
                r_out_status <= ST_GRANTED;
                r_out_credit <= r_pend_credit;
            end else begin
                r_out_id     <= r_rel_id;
                r_out_status <= ST_RELEASED;
                r_out_credit <= n_credit_low;
            end
        end
    end

    assign new_entry.owner  = in_id;
    assign new_entry.amount = in_amount;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        t_cell_ctrl cell_ctrl;
        t_waiter    cell_next;

        assign cell_ctrl.load   = obtain_acc && obt_queue && (r_total == CNT_W'(i));
        assign cell_ctrl.shift  = step_en;
        assign cell_ctrl.recirc = !head_ok && (r_total == CNT_W'(i + 1));

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign cell_next = '0;
        end else begin : g_mid
            assign cell_next = cell_q[i + 1];
        end

        csq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_new   (new_entry),
            .i_next  (cell_next),
            .i_head  (cell_q[0]),
            .o_entry (cell_q[i])
        );
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_credit, r_out_id};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(QUEUE_DEPTH))
        else $error("Waiter count exceeds the queue depth.");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_left <= r_total))
        else $error("Walk has more waiters left than are queued.");

    a_release_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        release_acc |=> (r_state == S_WALK))
        else $error("Release transaction did not start a walk.");

    a_obtain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        obtain_acc |=> (m_axis_tvalid && m_axis_tlast))
        else $error("Obtain transaction did not produce a final result.");
`endif

endmodule

`default_nettype wire
